@@ rtl/core/r2fft_pkg.sv @@
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared constants and the twiddle table of the radix-2 fft.
// ----------------------------------------------------------------------------
`default_nettype none

package r2fft_pkg;

    localparam int DATA_W = 24;
    localparam int TW_W   = 17;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [TW_W-1:0]   tw_t;

    // quarter wave cosine, round(32768*cos(2*pi*q/64)) for q = 0..16
    function automatic tw_t cos_quarter(input logic [4:0] q);
        tw_t v;
        begin
            case (q)
                5'd0:    v = 17'sd32768;
                5'd1:    v = 17'sd32610;
                5'd2:    v = 17'sd32138;
                5'd3:    v = 17'sd31357;
                5'd4:    v = 17'sd30274;
                5'd5:    v = 17'sd28899;
                5'd6:    v = 17'sd27246;
                5'd7:    v = 17'sd25330;
                5'd8:    v = 17'sd23170;
                5'd9:    v = 17'sd20788;
                5'd10:   v = 17'sd18205;
                5'd11:   v = 17'sd15447;
                5'd12:   v = 17'sd12540;
                5'd13:   v = 17'sd9512;
                5'd14:   v = 17'sd6393;
                5'd15:   v = 17'sd3212;
                default: v = 17'sd0;
            endcase
            return v;
        end
    endfunction

    // cos and sin of 2*pi*q/64, q in 0..31
    function automatic tw_t tw_cos(input logic [4:0] q);
        tw_t v;
        begin
            if (q <= 5'd16)
                v = cos_quarter(q);
            else
                v = -cos_quarter(5'd0 - q);
            return v;
        end
    endfunction

    function automatic tw_t tw_sin(input logic [4:0] q);
        tw_t v;
        begin
            if (q <= 5'd16)
                v = cos_quarter(5'd16 - q);
            else
                v = cos_quarter(q - 5'd16);
            return v;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/r2fft_ram.sv @@
// ----------------------------------------------------------------------------
// r2fft_ram
// Generic single write, single read ram with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module r2fft_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/radix2_fft_top.sv @@
// ----------------------------------------------------------------------------
// radix2_fft_top
// Radix-2 decimation-in-time fft over 2^size_log2 complex samples held in
// one ram; samples land in bit-reversed order, butterflies run in place.
// ----------------------------------------------------------------------------
// sequence: after the last sample of a frame, each butterfly steps through the
// states RA, RB, P1, P2, P3, WA and WB; then each bin steps through ORD, OCAP
// and OHOLD, where it waits for bin_ready. Samples of the next frame are taken
// only after the last bin; the pace is set by the single read port of the ram.
// reset: size_log2 returns to 6, the fill count clears, the ram is not cleared.
`default_nettype none

module radix2_fft_top #(
    parameter int MAX_POINTS  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        sample_valid,
    output logic             sample_ready,
    input  wire logic signed [15:0] sample_real,
    input  wire logic signed [15:0] sample_imag,
    output logic             bin_valid,
    input  wire logic        bin_ready,
    output logic signed [23:0] bin_real,
    output logic signed [23:0] bin_imag,
    output logic      [5:0]  bin_index,
    output logic             last_bin
);

    import r2fft_pkg::*;

    localparam int AW      = $clog2(MAX_POINTS);
    localparam int SB      = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
    localparam int PROD_W  = DATA_W + TW_W;
    // wider sample formats see the 16-bit port as a positive value
    localparam bit SIGN_IN = (SAMPLE_BITS <= 16);

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_RA    = 4'd1;
    localparam logic [3:0] ST_RB    = 4'd2;
    localparam logic [3:0] ST_P1    = 4'd3;
    localparam logic [3:0] ST_P2    = 4'd4;
    localparam logic [3:0] ST_P3    = 4'd5;
    localparam logic [3:0] ST_WA    = 4'd6;
    localparam logic [3:0] ST_WB    = 4'd7;
    localparam logic [3:0] ST_ORD   = 4'd8;
    localparam logic [3:0] ST_OCAP  = 4'd9;
    localparam logic [3:0] ST_OHOLD = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    size_reg;
    logic [AW:0]   fill_reg, fill_next;
    logic [2:0]    stage_reg, stage_next;
    logic [AW-1:0] bf_reg, bf_next;
    logic [AW-1:0] bin_reg, bin_next;

    data_t a_re_reg, a_im_reg, b_re_reg, b_im_reg;
    data_t pr_reg, pi_reg;
    logic signed [PROD_W-1:0] p1_reg, p2_reg, p3_reg, p4_reg;

    logic [2:0]    lg;
    logic [AW:0]   n_pts;
    logic [AW-1:0] half_mask, addr_a, addr_b, rev_addr, fill_lo;
    logic [4:0]    jq;
    tw_t           w_re, w_im;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [2*DATA_W-1:0]     ram_wdata, ram_rdata;
    data_t                   rd_re, rd_im;
    logic                    cfg_wr;
    logic signed [PROD_W:0]  sum_r, sum_i;
    logic signed [SB-1:0]    s_re, s_im;
    data_t                   ext_re, ext_im;

    r2fft_ram #(
        .WIDTH (2*DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_re  = ram_rdata[2*DATA_W-1:DATA_W];
    assign rd_im  = ram_rdata[DATA_W-1:0];
    assign pready = 1'b1;
    assign prdata = {29'd0, size_reg};
    assign cfg_wr = psel && penable && pwrite && !paddr[2];

    // active length, clamped to the supported range
    always_comb
    begin
        if (size_reg < 3'd1)
            lg = 3'd1;
        else if (size_reg > 3'(AW))
            lg = 3'(AW);
        else
            lg = size_reg;
    end

    assign n_pts     = (AW+1)'(1) << lg;
    assign half_mask = AW'(((AW+1)'(1) << stage_reg) >> 1) - AW'(1);
    assign addr_a    = ((bf_reg & ~half_mask) << 1) | (bf_reg & half_mask);
    assign addr_b    = addr_a | (half_mask + AW'(1));
    assign jq        = 5'(bf_reg & half_mask) << (3'd6 - stage_reg);
    assign w_re      = tw_cos(jq);
    assign w_im      = -tw_sin(jq);
    assign fill_lo   = fill_reg[AW-1:0];

    // bit-reversed write address for the incoming sample
    always_comb
    begin
        logic [AW-1:0] r;
        r = '0;
        for (int i = 0; i < AW; i++)
            r[i] = fill_lo[AW-1-i];
        rev_addr = r >> (3'(AW) - lg);
    end

    assign s_re   = sample_real[SB-1:0];
    assign s_im   = sample_imag[SB-1:0];
    assign ext_re = {{(DATA_W-SB){SIGN_IN & s_re[SB-1]}}, s_re};
    assign ext_im = {{(DATA_W-SB){SIGN_IN & s_im[SB-1]}}, s_im};
    assign sum_r = (PROD_W+1)'(p1_reg) - (PROD_W+1)'(p2_reg) + (PROD_W+1)'(16384);
    assign sum_i = (PROD_W+1)'(p3_reg) + (PROD_W+1)'(p4_reg) + (PROD_W+1)'(16384);

    assign sample_ready = (state_reg == ST_LOAD);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        stage_next = stage_reg;
        bf_next    = bf_reg;
        bin_next   = bin_reg;
        ram_we     = 1'b0;
        ram_waddr  = addr_a;
        ram_wdata  = {a_re_reg + pr_reg, a_im_reg + pi_reg};
        ram_raddr  = addr_a;
        case (state_reg)
            ST_LOAD:
            begin
                ram_waddr = rev_addr;
                ram_wdata = {ext_re, ext_im};
                if (sample_valid)
                begin
                    ram_we = 1'b1;
                    if (fill_reg + (AW+1)'(1) == n_pts)
                    begin
                        fill_next  = '0;
                        stage_next = 3'd1;
                        bf_next    = '0;
                        state_next = ST_RA;
                    end
                    else
                        fill_next = fill_reg + (AW+1)'(1);
                end
            end
            ST_RA:   state_next = ST_RB;
            ST_RB:
            begin
                ram_raddr  = addr_b;
                state_next = ST_P1;
            end
            ST_P1:   state_next = ST_P2;
            ST_P2:   state_next = ST_P3;
            ST_P3:   state_next = ST_WA;
            ST_WA:
            begin
                ram_we     = 1'b1;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                ram_we     = 1'b1;
                ram_waddr  = addr_b;
                ram_wdata  = {a_re_reg - pr_reg, a_im_reg - pi_reg};
                state_next = ST_RA;
                if ({1'b0, bf_reg} == (n_pts >> 1) - (AW+1)'(1))
                begin
                    bf_next = '0;
                    if (stage_reg == lg)
                    begin
                        bin_next   = '0;
                        state_next = ST_ORD;
                    end
                    else
                        stage_next = stage_reg + 3'd1;
                end
                else
                    bf_next = bf_reg + AW'(1);
            end
            ST_ORD:
            begin
                ram_raddr  = bin_reg;
                state_next = ST_OCAP;
            end
            ST_OCAP: state_next = ST_OHOLD;
            ST_OHOLD:
            begin
                if (bin_ready)
                begin
                    if ({1'b0, bin_reg} == n_pts - (AW+1)'(1))
                        state_next = ST_LOAD;
                    else
                    begin
                        bin_next   = bin_reg + AW'(1);
                        state_next = ST_ORD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
        if (cfg_wr)
            fill_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            size_reg  <= 3'd6;
            fill_reg  <= '0;
            stage_reg <= 3'd1;
            bf_reg    <= '0;
            bin_reg   <= '0;
            bin_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            stage_reg <= stage_next;
            bf_reg    <= bf_next;
            bin_reg   <= bin_next;
            if (cfg_wr)
                size_reg <= pwdata[2:0];
            if (state_reg == ST_OCAP)
                bin_valid <= 1'b1;
            else if (bin_ready)
                bin_valid <= 1'b0;
        end
    end

    // butterfly datapath and output holding registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_RB:
            begin
                a_re_reg <= rd_re;
                a_im_reg <= rd_im;
            end
            ST_P1:
            begin
                b_re_reg <= rd_re;
                b_im_reg <= rd_im;
                p1_reg   <= rd_re * w_re;
                p2_reg   <= rd_im * w_im;
            end
            ST_P2:
            begin
                p3_reg <= b_re_reg * w_im;
                p4_reg <= b_im_reg * w_re;
                pr_reg <= DATA_W'(sum_r >>> 15);
            end
            ST_P3:   pi_reg <= DATA_W'(sum_i >>> 15);
            ST_OCAP:
            begin
                bin_real  <= rd_re;
                bin_imag  <= rd_im;
                bin_index <= 6'(bin_reg);
                last_bin  <= ({1'b0, bin_reg} == n_pts - (AW+1)'(1));
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for radix2_fft_top: streams complex samples under random gaps
// and stalls, predicts every bin with a fixed-point fft of its own and checks
// the bins in order. The transform size is reprogrammed between frames.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int NPTS  = 64;
    localparam int LIMIT = 2000000;
    localparam logic [2:0] ADDR_SIZE_LOG2 = 3'd0;
    localparam logic [2:0] ADDR_UNUSED    = 3'd4;

    typedef struct packed {
        logic signed [23:0] re;
        logic signed [23:0] im;
        logic [5:0]         idx;
        logic               last;
    } bin_t;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               has_exp;
        logic signed [23:0] exp_re;
        logic signed [23:0] exp_im;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic sample_valid = 1'b0;
    logic sample_ready;
    logic signed [15:0] sample_real = '0, sample_imag = '0;
    logic bin_valid;
    logic bin_ready = 1'b0;
    logic signed [23:0] bin_real, bin_imag;
    logic [5:0] bin_index;
    logic last_bin;

    radix2_fft_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .sample_valid(sample_valid), .sample_ready(sample_ready),
        .sample_real(sample_real), .sample_imag(sample_imag),
        .bin_valid(bin_valid), .bin_ready(bin_ready),
        .bin_real(bin_real), .bin_imag(bin_imag),
        .bin_index(bin_index), .last_bin(last_bin)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [2:0] size_reg;
    logic signed [63:0] frame_re [NPTS];
    logic signed [63:0] frame_im [NPTS];
    int fill;
    bin_t expected_bins [$];
    // directed known values, applied to bin 0 of the next frame
    logic pin_bin0;
    logic signed [23:0] pin_re, pin_im;

    int errors = 0;
    int cycles = 0;
    int bins_seen = 0;
    logic stall_out = 1'b0;
    int stall_left = 0;

    localparam int COS_Q [17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246,
        25330, 23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

    function automatic int frame_log();
        if (size_reg < 3'd1)
            return 1;
        if (size_reg > 3'd6)
            return 6;
        return int'(size_reg);
    endfunction

    function automatic logic signed [63:0] round_q15(input logic signed [63:0] x);
        return (x + 64'sd16384) >>> 15;
    endfunction

    task automatic run_fft(input int lg);
        int n, r, t, m, half;
        logic signed [63:0] tmp, c, sn, wr, wi, pr, pi, br, bi;
        int q;
        n = 1 << lg;
        for (int i = 0; i < n; i++)
        begin
            r = 0;
            t = i;
            for (int b = 0; b < lg; b++)
            begin
                r = (r << 1) | (t & 1);
                t = t >> 1;
            end
            if (i < r)
            begin
                tmp = frame_re[i]; frame_re[i] = frame_re[r]; frame_re[r] = tmp;
                tmp = frame_im[i]; frame_im[i] = frame_im[r]; frame_im[r] = tmp;
            end
        end
        for (int s = 1; s <= lg; s++)
        begin
            m = 1 << s;
            half = m >> 1;
            for (int k = 0; k < n; k += m)
            begin
                for (int j = 0; j < half; j++)
                begin
                    q = (j << (6 - s)) & 31;
                    if (q <= 16)
                    begin
                        c = COS_Q[q];
                        sn = COS_Q[16 - q];
                    end
                    else
                    begin
                        c = -COS_Q[32 - q];
                        sn = COS_Q[q - 16];
                    end
                    wr = c;
                    wi = -sn;
                    br = frame_re[k + j + half];
                    bi = frame_im[k + j + half];
                    pr = round_q15(br * wr - bi * wi);
                    pi = round_q15(br * wi + bi * wr);
                    frame_re[k + j + half] = frame_re[k + j] - pr;
                    frame_im[k + j + half] = frame_im[k + j] - pi;
                    frame_re[k + j] = frame_re[k + j] + pr;
                    frame_im[k + j] = frame_im[k + j] + pi;
                end
            end
        end
    endtask

    task automatic take_sample(input logic signed [15:0] re, input logic signed [15:0] im);
        int lg, n;
        bin_t b;
        lg = frame_log();
        n = 1 << lg;
        if (fill >= n)
            fill = 0;
        frame_re[fill] = re;
        frame_im[fill] = im;
        fill++;
        if (fill == n)
        begin
            run_fft(lg);
            for (int k = 0; k < n; k++)
            begin
                b.re = frame_re[k][23:0];
                b.im = frame_im[k][23:0];
                b.idx = k[5:0];
                b.last = (k == n - 1);
                if (k == 0 && pin_bin0)
                begin
                    // typed-in value must agree with the fft of the frame
                    if (b.re !== pin_re || b.im !== pin_im)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("directed bin0 expected %0d %0d, predicted %0d %0d",
                                     pin_re, pin_im, b.re, b.im);
                    end
                    b.re = pin_re;
                    b.im = pin_im;
                    pin_bin0 = 1'b0;
                end
                expected_bins.push_back(b);
            end
            fill = 0;
        end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_SIZE_LOG2)
        begin
            size_reg = data[2:0];
            fill = 0;
        end
    endtask

    task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                               input logic allow_gap);
        int gap;
        if (allow_gap && $urandom_range(0, 3) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_real <= re;
        sample_imag <= im;
        do @(posedge clk); while (!sample_ready);
        take_sample(re, im);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (expected_bins.size() != 0)
            @(negedge clk);
        // partial frames cause no bins; give the block time to settle
        repeat (3000) @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_sample(input int mode);
        case (mode)
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return $signed(16'($urandom_range(0, 255)) - 16'd128);
            default: return $signed(16'($urandom));
        endcase
    endfunction

    // bin checker
    always @(posedge clk)
    begin
        bin_t exp_b;
        if (rst_n && bin_valid && bin_ready)
        begin
            bins_seen++;
            if (expected_bins.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected bin index %0d", bin_index);
            end
            else
            begin
                exp_b = expected_bins.pop_front();
                if (bin_real !== exp_b.re || bin_imag !== exp_b.im ||
                    bin_index !== exp_b.idx || last_bin !== exp_b.last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("bin mismatch: expected re %0d im %0d idx %0d last %0b, got re %0d im %0d idx %0d last %0b",
                                 exp_b.re, exp_b.im, exp_b.idx, exp_b.last,
                                 bin_real, bin_imag, bin_index, last_bin);
                end
            end
        end
    end

    // consumer stalls: mostly short, now and then a long one
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            bin_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_out && $urandom_range(0, 49) == 0)
        begin
            bin_ready <= 1'b0;
            stall_left <= $urandom_range(10, 40);
        end
        else if (stall_out)
            bin_ready <= ($urandom_range(0, 3) != 0);
        else
            bin_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    stim_row_t directed [$];

    initial
    begin
        stim_row_t row;
        int lg;
        int mode;
        size_reg = 3'd6;
        fill = 0;
        pin_bin0 = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: size 1 frames with extremes; bin 0 is the plain sum
        apb_write(ADDR_SIZE_LOG2, 32'd1);
        directed.push_back('{16'sh7FFF, 16'sh7FFF, 1'b0, 24'sd0, 24'sd0});
        directed.push_back('{16'sh7FFF, 16'sh7FFF, 1'b1, 24'sd65534, 24'sd65534});
        directed.push_back('{16'sh8000, 16'sh8000, 1'b0, 24'sd0, 24'sd0});
        directed.push_back('{16'sh8000, 16'sh8000, 1'b1, -24'sd65536, -24'sd65536});
        directed.push_back('{16'sh7FFF, 16'sh8000, 1'b0, 24'sd0, 24'sd0});
        directed.push_back('{16'sh8000, 16'sh7FFF, 1'b1, -24'sd1, -24'sd1});
        directed.push_back('{16'sh5555, 16'shAAAA, 1'b0, 24'sd0, 24'sd0});
        directed.push_back('{16'shAAAA, 16'sh5555, 1'b1, -24'sd1, -24'sd1});
        foreach (directed[i])
        begin
            row = directed[i];
            if (row.has_exp)
            begin
                pin_bin0 = 1'b1;
                pin_re = row.exp_re;
                pin_im = row.exp_im;
            end
            send_sample(row.re, row.im, 1'b0);
        end
        sample_valid <= 1'b0;
        wait_drained();

        // write to an unused address is ignored; size 0 acts as size 1
        apb_write(ADDR_UNUSED, 32'd3);
        apb_write(ADDR_SIZE_LOG2, 32'd0);
        send_sample(16'sd1, 16'sd0, 1'b0);
        send_sample(16'sd0, 16'sd1, 1'b0);
        sample_valid <= 1'b0;
        wait_drained();
        // partial frame dropped by the size write; size 7 acts as 6
        apb_write(ADDR_SIZE_LOG2, 32'd2);
        send_sample(16'sd100, -16'sd100, 1'b0);
        sample_valid <= 1'b0;
        wait_drained();
        apb_write(ADDR_SIZE_LOG2, 32'd7);
        for (int i = 0; i < 64; i++)
            send_sample(i[0] ? 16'sh7FFF : 16'sh8000, rand_sample(3), 1'b0);
        sample_valid <= 1'b0;
        wait_drained();

        // random phases with gaps and stalls
        stall_out = 1'b1;
        for (int ph = 0; ph < 8; ph++)
        begin
            lg = (ph == 0) ? 6 : (ph == 1) ? 1 : $urandom_range(1, 5);
            apb_write(ADDR_SIZE_LOG2, 32'(lg));
            mode = $urandom_range(0, 3);
            for (int i = 0; i < (ph == 0 ? 64 : 30); i++)
                send_sample(rand_sample($urandom_range(0, 9) == 0 ? mode : 3),
                            rand_sample(3), 1'b1);
            sample_valid <= 1'b0;
            wait_drained();
        end
        // back to reset size, one more frame
        apb_write(ADDR_SIZE_LOG2, 32'd6);
        for (int i = 0; i < 64; i++)
            send_sample(rand_sample(3), rand_sample(3), 1'b1);
        sample_valid <= 1'b0;
        wait_drained();

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
